FILE: hdl/mtfo_pkg.sv
package mtfo_pkg;

  // Generator constants.
  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] TWIST_XOR  = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B   = 32'd2636928640;
  localparam logic [31:0] TEMPER_C   = 32'd4022730752;
  localparam logic [31:0] UPPER_BIT  = 32'h80000000;
  localparam logic [31:0] LOW_MASK   = 32'h7fffffff;
  localparam int          INIT_STEPS = 398;
  localparam int          TAP_OFFSET = 397;

  // Word carried down the initialization pipeline.
  typedef struct packed {
    logic        valid;
    logic [31:0] seed;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] wt0;
    logic [31:0] w;
  } init_stage_t;

  // First-twist combination of two state words and a tap word.
  function automatic logic [31:0] mt_twist(input logic [31:0] hi_src,
                                           input logic [31:0] lo_src,
                                           input logic [31:0] tap);
    logic [31:0] joined;
    logic [31:0] r;
    joined = (hi_src & UPPER_BIT) | (lo_src & LOW_MASK);
    r = tap ^ (joined >> 1);
    if (joined[0]) begin
      r = r ^ TWIST_XOR;
    end
    return r;
  endfunction

  // Output tempering.
  function automatic logic [31:0] mt_temper(input logic [31:0] v_in);
    logic [31:0] v;
    v = v_in;
    v = v ^ (v >> 11);
    v = v ^ ((v << 7) & TEMPER_B);
    v = v ^ ((v << 15) & TEMPER_C);
    v = v ^ (v >> 18);
    return v;
  endfunction

endpackage

FILE: hdl/mt19937_first_two_odd_multipliers.sv
// Turns each 32-bit seed into the seed and two odd 31-bit multipliers taken
// from the first two tempered MT19937 outputs for that seed.
// Input channel: a word on in_seed_word is taken at a rising edge with start
// high and busy low. busy is always low, so a new seed can be given in every
// cycle.
// Result channel: out_valid is high for one cycle with out_seed_echo,
// out_x_multiplier and out_z_multiplier. The receiver cannot stall, and the
// pipeline never needs to, so the output moves on every clock.
// The pipeline has 398 recurrence stages, each one 32x32 multiply and add,
// then one stage for the twist and one for tempering. Throughput is one
// seed per cycle.
// Configuration: cfg_we with cfg_wdata writes the feature key register. The
// key is only held in its register and does not change any result.
// Reset (rst_n low, synchronous) clears all valid bits and the feature key;
// seeds in flight are dropped.
module mt19937_first_two_odd_multipliers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_seed_word,
  output logic        out_valid,
  output logic [31:0] out_seed_echo,
  output logic [30:0] out_x_multiplier,
  output logic [30:0] out_z_multiplier,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import mtfo_pkg::*;

  init_stage_t chain [0:INIT_STEPS];

  logic        twist_valid_r;
  logic [31:0] twist_seed_r;
  logic [31:0] twist_x_r;
  logic [31:0] twist_z_r;
  logic        out_valid_r;
  logic [31:0] out_seed_r;
  logic [31:0] temper_x;
  logic [31:0] temper_z;
  logic [30:0] out_x_r;
  logic [30:0] out_z_r;
  logic [31:0] feature_key_r;

  // Feature key register, held for the record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_key_r <= '0;
    end else if (cfg_we) begin
      feature_key_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Head of the pipeline.
  assign chain[0] = '{valid: start, seed: in_seed_word, w1: '0, w2: '0, wt0: '0,
                      w: in_seed_word};

  // Recurrence stages, one per initialization step.
  for (genvar g = 1; g <= INIT_STEPS; g++) begin : g_init
    mtfo_init_stage #(
      .STEP(g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_in (chain[g-1]),
      .stage_out(chain[g])
    );
  end

  // Twist stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twist_valid_r <= 1'b0;
    end else begin
      twist_valid_r <= chain[INIT_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    twist_seed_r <= chain[INIT_STEPS].seed;
    twist_x_r    <= mt_twist(chain[INIT_STEPS].seed, chain[INIT_STEPS].w1,
                             chain[INIT_STEPS].wt0);
    twist_z_r    <= mt_twist(chain[INIT_STEPS].w1, chain[INIT_STEPS].w2,
                             chain[INIT_STEPS].w);
  end

  // Temper stage: shift right one and force the multiplier odd.
  assign temper_x = mt_temper(twist_x_r);
  assign temper_z = mt_temper(twist_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= twist_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_seed_r <= twist_seed_r;
    out_x_r    <= {temper_x[31:2], 1'b1};
    out_z_r    <= {temper_z[31:2], 1'b1};
  end

  assign out_valid        = out_valid_r;
  assign out_seed_echo    = out_seed_r;
  assign out_x_multiplier = out_x_r;
  assign out_z_multiplier = out_z_r;

endmodule

FILE: hdl/mtfo_init_stage.sv
module mtfo_init_stage #(
  parameter int STEP = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtfo_pkg::init_stage_t stage_in,
  output mtfo_pkg::init_stage_t stage_out
);
  import mtfo_pkg::*;

  logic [31:0] mix;
  logic [31:0] prod;
  logic [31:0] w_nxt;
  init_stage_t stage_r;
  init_stage_t stage_nxt;

  // One step of the initialization recurrence: one multiply and one add.
  always_comb begin
    mix   = stage_in.w ^ (stage_in.w >> 30);
    prod  = mix * INIT_MULT;
    w_nxt = prod + 32'(STEP);
  end

  // Capture the words that the first twist needs as they go by.
  always_comb begin
    stage_nxt     = stage_in;
    stage_nxt.w   = w_nxt;
    if (STEP == 1) begin
      stage_nxt.w1 = w_nxt;
    end
    if (STEP == 2) begin
      stage_nxt.w2 = w_nxt;
    end
    if (STEP == TAP_OFFSET) begin
      stage_nxt.wt0 = w_nxt;
    end
  end

  // Stage register; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.seed <= stage_nxt.seed;
    stage_r.w1   <= stage_nxt.w1;
    stage_r.w2   <= stage_nxt.w2;
    stage_r.wt0  <= stage_nxt.wt0;
    stage_r.w    <= stage_nxt.w;
  end

  assign stage_out = stage_r;

endmodule

FILE: hdl/mtfo_checker.sv
module mtfo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_seed_word,
  input logic        out_valid,
  input logic [31:0] out_seed_echo,
  input logic [30:0] out_x_multiplier,
  input logic [30:0] out_z_multiplier
);
  import mtfo_pkg::*;

  localparam int LATENCY = INIT_STEPS + 2;
  localparam int CNT_W   = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] since_rst_r;

  // Cycles since reset, saturating at the pipeline latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_rst_r <= '0;
    end else if (since_rst_r != CNT_W'(LATENCY)) begin
      since_rst_r <= since_rst_r + 1'b1;
    end
  end

  // No word leaves before the pipeline has filled since reset.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (since_rst_r != CNT_W'(LATENCY)) |-> !out_valid)
    else $error("result word before pipeline latency after reset");

  // Each accepted seed gives exactly one result, a fixed latency later.
  a_one_per_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (since_rst_r == CNT_W'(LATENCY)) |->
      (out_valid == $past(start && !busy, LATENCY)))
    else $error("result word does not match accepted seed");

  // The echoed seed is the one accepted a latency earlier.
  a_seed_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seed_echo == $past(in_seed_word, LATENCY)))
    else $error("seed echo mismatch");

  // Both multipliers are odd.
  a_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_multiplier[0] && out_z_multiplier[0]))
    else $error("multiplier is even");

endmodule

bind mt19937_first_two_odd_multipliers mtfo_checker u_mtfo_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_seed_word    (in_seed_word),
  .out_valid       (out_valid),
  .out_seed_echo   (out_seed_echo),
  .out_x_multiplier(out_x_multiplier),
  .out_z_multiplier(out_z_multiplier)
);

FILE: dv/mt19937_multiplier_checker.sv
// Watches the seed and result channels of the MT19937 multiplier block.
// Each seed it sees accepted gets a predicted result record. Each result
// word is compared with the oldest prediction.
module mt19937_multiplier_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_seed_word,
  input  logic        out_valid,
  input  logic [31:0] out_seed_echo,
  input  logic [30:0] out_x_multiplier,
  input  logic [30:0] out_z_multiplier,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          outstanding,
  output int          mismatches,
  output int          results_seen
);

  import mtfo_pkg::*;

  // Generator constants as the checker uses them.
  localparam logic [31:0] SEED_MULT   = 32'd1812433253;
  localparam logic [31:0] MATRIX_A    = 32'h9908b0df;
  localparam logic [31:0] MASK_B      = 32'h9d2c5680;
  localparam logic [31:0] MASK_C      = 32'hefc60000;
  localparam int          LAST_STEP   = 398;
  localparam int          FIRST_TAP   = 397;

  // One predicted result word.
  typedef struct packed {
    logic [31:0] seed;
    logic [30:0] x_mult;
    logic [30:0] z_mult;
  } seed_result_t;

  seed_result_t pending_multipliers[$];
  logic [31:0]  feature_key_copy;

  // Combines the upper bit of one state word with the lower bits of the next
  // and folds in the tap word, as the first twist does.
  function automatic logic [31:0] twisted_word(input logic [31:0] upper_src,
                                               input logic [31:0] lower_src,
                                               input logic [31:0] tap);
    logic [31:0] y;
    y = {upper_src[31], lower_src[30:0]};
    return tap ^ {1'b0, y[31:1]} ^ (y[0] ? MATRIX_A : 32'h0);
  endfunction

  // Standard output tempering.
  function automatic logic [31:0] tempered(input logic [31:0] raw);
    logic [31:0] y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MASK_B);
    y = y ^ ((y << 15) & MASK_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Expands a seed through the initialization recurrence and forms both
  // odd multipliers from the first two tempered outputs.
  function automatic seed_result_t odd_multipliers_of(input logic [31:0] seed);
    seed_result_t r;
    logic [31:0]  w;
    logic [31:0]  w1;
    logic [31:0]  w2;
    logic [31:0]  tap0;
    logic [31:0]  tap1;
    logic [31:0]  t0;
    logic [31:0]  t1;
    w = seed;
    w1 = '0;
    w2 = '0;
    tap0 = '0;
    tap1 = '0;
    for (int k = 1; k <= LAST_STEP; k++) begin
      w = SEED_MULT * (w ^ (w >> 30)) + 32'(k);
      if (k == 1) w1 = w;
      if (k == 2) w2 = w;
      if (k == FIRST_TAP) tap0 = w;
      if (k == FIRST_TAP + 1) tap1 = w;
    end
    t0 = tempered(twisted_word(seed, w1, tap0));
    t1 = tempered(twisted_word(w1, w2, tap1));
    r.seed = seed;
    r.x_mult = t0[31:1] | 31'd1;
    r.z_mult = t1[31:1] | 31'd1;
    return r;
  endfunction

  // Prediction on accepted seeds, comparison on result words.
  always @(posedge clk) begin
    seed_result_t want;
    if (!rst_n) begin
      pending_multipliers.delete();
      feature_key_copy = '0;
      outstanding <= 0;
    end else begin
      // The key is only copied and changes no result.
      if (cfg_we) begin
        feature_key_copy = cfg_wdata;
      end
      if (start && !busy) begin
        pending_multipliers.insert(pending_multipliers.size(),
                                   odd_multipliers_of(in_seed_word));
      end
      if ($isunknown(out_valid)) begin
        $display("%0t: out_valid expected a known value, got %b", $time, out_valid);
        mismatches++;
      end else if (out_valid) begin
        results_seen++;
        if (pending_multipliers.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got seed %h x %h z %h",
                   $time, out_seed_echo, out_x_multiplier, out_z_multiplier);
          mismatches++;
        end else begin
          want = pending_multipliers.pop_front();
          if (out_seed_echo !== want.seed) begin
            $display("%0t: seed_echo expected %h, got %h", $time, want.seed, out_seed_echo);
            mismatches++;
          end
          if (out_x_multiplier !== want.x_mult) begin
            $display("%0t: x_multiplier for seed %h expected %h, got %h",
                     $time, want.seed, want.x_mult, out_x_multiplier);
            mismatches++;
          end
          if (out_z_multiplier !== want.z_mult) begin
            $display("%0t: z_multiplier for seed %h expected %h, got %h",
                     $time, want.seed, want.z_mult, out_z_multiplier);
            mismatches++;
          end
        end
      end
      outstanding <= pending_multipliers.size();
    end
  end

endmodule

FILE: dv/mt19937_first_two_odd_multipliers_tb.sv
module mt19937_first_two_odd_multipliers_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PIPE_DEPTH    = 400;
  localparam int RANDOM_GAPPED = 800;
  localparam int RANDOM_DENSE  = 280;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_seed_word;
  logic        out_valid;
  logic [31:0] out_seed_echo;
  logic [30:0] out_x_multiplier;
  logic [30:0] out_z_multiplier;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  int outstanding;
  int mismatches;
  int results_seen;
  int cycles;
  int seeds_sent;
  int key_writes;

  mt19937_first_two_odd_multipliers dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_seed_word     (in_seed_word),
    .out_valid        (out_valid),
    .out_seed_echo    (out_seed_echo),
    .out_x_multiplier (out_x_multiplier),
    .out_z_multiplier (out_z_multiplier),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  mt19937_multiplier_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_seed_word     (in_seed_word),
    .out_valid        (out_valid),
    .out_seed_echo    (out_seed_echo),
    .out_x_multiplier (out_x_multiplier),
    .out_z_multiplier (out_z_multiplier),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .outstanding      (outstanding),
    .mismatches       (mismatches),
    .results_seen     (results_seen)
  );

  // Clock with a period of 10.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one seed word and holds it until the block takes it.
  task automatic send_seed(input logic [31:0] seed);
    in_seed_word <= seed;
    start <= 1'b1;
    seeds_sent++;
    do @(posedge clk); while (busy);
  endtask

  // Leaves the input channel idle for a number of cycles.
  task automatic pause_input(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stops sending and waits until every predicted result word has come.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes the feature key while the block is idle.
  task automatic write_key(input logic [31:0] key);
    cfg_we <= 1'b1;
    cfg_wdata <= key;
    key_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random seed with a bias toward the ends of the range and single bits.
  function automatic logic [31:0] random_seed();
    case ($urandom_range(0, 9))
      0: return 32'($urandom_range(0, 255));
      1: return 32'hffffffff - 32'($urandom_range(0, 255));
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Random seeds, with idle bursts on the input side when with_gaps is set.
  task automatic send_random_seeds(input int count, input bit with_gaps);
    for (int i = 0; i < count; i++) begin
      if (with_gaps && $urandom_range(0, 4) == 0) begin
        pause_input($urandom_range(1, 12));
      end
      send_seed(random_seed());
    end
  endtask

  initial begin
    logic [31:0] corner_seeds[$];
    corner_seeds = '{32'h0, 32'hffffffff, 32'h1, 32'h80000000, 32'h7fffffff,
                     32'd5489, 32'haaaaaaaa, 32'h55555555, 32'h2, 32'hfffffffe,
                     32'h40000000, 32'hc0000000, 32'h12345678, 32'h0, 32'hffffffff};
    rst_n = 1'b0;
    start = 1'b0;
    in_seed_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cycles = 0;
    seeds_sent = 0;
    key_writes = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed seeds back to back, with the key at its top value.
    write_key(32'hffffffff);
    foreach (corner_seeds[i]) begin
      send_seed(corner_seeds[i]);
    end
    drain_results();

    // Random seeds with gaps, the sender waiting out the pipeline midway.
    write_key(32'h0);
    send_random_seeds(RANDOM_GAPPED / 2, 1'b1);
    drain_results();
    write_key($urandom);
    send_random_seeds(RANDOM_GAPPED / 2, 1'b1);
    drain_results();

    // Dense stretch at the end with no idle cycles.
    write_key(32'h80000000);
    send_random_seeds(RANDOM_DENSE, 1'b0);
    drain_results();

    // Let the pipeline run empty to catch any stray result word.
    repeat (PIPE_DEPTH + 20) @(posedge clk);

    $display("Run covered %0d seeds, directed corners and random ones, with %0d results checked.",
             seeds_sent, results_seen);
    $display("The feature key took %0d settings, including all zeros and all ones.",
             key_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mtfo_pkg.sv
hdl/mtfo_init_stage.sv
hdl/mt19937_first_two_odd_multipliers.sv
hdl/mtfo_checker.sv
dv/mt19937_multiplier_checker.sv
dv/mt19937_first_two_odd_multipliers_tb.sv
